// File: src/ilid_pkg.sv
`default_nettype none

package ilid_pkg;

    localparam int WORD_W  = 32;
    localparam int POS_W   = 7;
    localparam int TOTAL_W = 7;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [1:0]               t_req_type;
    typedef logic [1:0]               t_status;

    // request codes
    localparam t_req_type REQ_INS_AT   = 2'd0;
    localparam t_req_type REQ_DEL_AT   = 2'd1;
    localparam t_req_type REQ_INS_LAST = 2'd2;
    localparam t_req_type REQ_DEL_LAST = 2'd3;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

    // registered OR-tree levels: radix 8, at least one level
    function automatic int ilid_levels(input int depth);
        int l;
        l = ($clog2(depth) + 2) / 3;
        return (l < 1) ? 1 : l;
    endfunction

endpackage

`default_nettype wire

// File: src/ilid_cell.sv
`default_nettype none

module ilid_cell #(
    parameter int IDX   = 0,
    parameter int CMP_W = 7
) (
    input  wire                   i_clk,
    input  ilid_pkg::t_cell_cmd   i_cmd,
    input  wire  [CMP_W-1:0]      i_tgt,
    input  wire  [CMP_W-1:0]      i_cnt,
    input  ilid_pkg::t_word       i_word_in,
    input  ilid_pkg::t_word       i_left,
    input  ilid_pkg::t_word       i_right,
    output ilid_pkg::t_word       o_word,
    output ilid_pkg::t_word       o_sel_word
);
    import ilid_pkg::*;

    localparam logic [CMP_W-1:0] L_IDX    = CMP_W'(IDX);
    localparam logic [CMP_W-1:0] L_IDX_P1 = CMP_W'(IDX + 1);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_cmd.ins) begin
            if (L_IDX == i_tgt) begin
                n_word = i_word_in;
            end else if ((L_IDX > i_tgt) && (L_IDX <= i_cnt)) begin
                n_word = i_left;
            end
        end else if (i_cmd.del) begin
            if ((L_IDX >= i_tgt) && (L_IDX_P1 < i_cnt)) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_sel_word = (i_cmd.del && (L_IDX == i_tgt)) ? r_word : '0;

endmodule

`default_nettype wire

// File: src/ilid_or_tree.sv
`default_nettype none

module ilid_or_tree #(
    parameter int DEPTH = 64
) (
    input  wire             i_clk,
    input  ilid_pkg::t_word i_leaf [DEPTH],
    output ilid_pkg::t_word o_root
);
    import ilid_pkg::*;

    function automatic int tree_nodes(input int l);
        return (DEPTH + (1 << (3 * l)) - 1) >> (3 * l);
    endfunction

    function automatic int tree_off(input int l);
        int s;
        s = 0;
        for (int k = 1; k < l; k++) begin
            s = s + tree_nodes(k);
        end
        return s;
    endfunction

    localparam int LEVELS = ilid_levels(DEPTH);
    localparam int TOTAL  = tree_off(LEVELS + 1);

    t_word r_node [TOTAL];

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int NCUR  = tree_nodes(l);
        localparam int NPREV = (l == 1) ? DEPTH : tree_nodes(l - 1);
        localparam int OCUR  = tree_off(l);
        localparam int OPREV = tree_off(l - 1);
        for (genvar n = 0; n < NCUR; n++) begin : g_node
            t_word w_child [8];
            t_word n_node;
            for (genvar j = 0; j < 8; j++) begin : g_child
                if (8 * n + j >= NPREV) begin : g_pad
                    assign w_child[j] = '0;
                end else if (l == 1) begin : g_leaf
                    assign w_child[j] = i_leaf[8 * n + j];
                end else begin : g_inner
                    assign w_child[j] = r_node[OPREV + 8 * n + j];
                end
            end
            always_comb begin
                n_node = '0;
                for (int j = 0; j < 8; j++) begin
                    n_node = n_node | w_child[j];
                end
            end
            always_ff @(posedge i_clk) begin
                r_node[OCUR + n] <= n_node;
            end
        end
    end

    assign o_root = r_node[TOTAL - 1];

endmodule

`default_nettype wire

// File: src/indexed_list_insert_delete_unit.sv
`default_nettype none

// Indexed list unit: an ordered list of up to DEPTH signed 32-bit words.
//
// Request channel: drive i_req_type, i_position and i_word_in with start high;
// the request is taken at the rising edge where start is high and busy is low.
// Request types: insert at index, delete at index, insert last, delete last.
//
// Result channel: every request gives exactly one result, shown for one cycle
// with o_done high: o_removed_word (word taken out by a good delete, else
// zero), o_element_total (count after the request) and o_status (ok, full,
// empty, index out of range). The receiver cannot stall; results are never
// held back.
//
// Storage is a row of DEPTH cells; the cells from the target on shift to their
// neighbors in the same cycle, so a request is taken every cycle while busy is
// low. The removed word is gathered by a registered radix-8 OR tree of
// ceil(log2(DEPTH)/3) levels; valid, total and status travel alongside the
// tree levels, and results come out in request order.
//
// Reset (synchronous, active low) empties the list and flushes results in
// flight; busy is high during reset and for the cycle after it.
module indexed_list_insert_delete_unit #(
    parameter int DEPTH = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  ilid_pkg::t_req_type   i_req_type,
    input  wire  [6:0]            i_position,
    input  ilid_pkg::t_word       i_word_in,
    output logic                  o_done,
    output ilid_pkg::t_word       o_removed_word,
    output logic [6:0]            o_element_total,
    output ilid_pkg::t_status     o_status
);
    import ilid_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEVELS = ilid_levels(DEPTH);
    localparam logic [CNT_W-1:0] L_DEPTH = CNT_W'(DEPTH);

    logic                   r_rdy;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic [CMP_W-1:0]       w_pos;
    logic [CMP_W-1:0]       w_cnt;
    logic [CMP_W-1:0]       w_tgt;
    t_status                w_status;
    t_cell_cmd              w_cmd;

    t_word                  w_cell_word [DEPTH];
    t_word                  w_sel_word  [DEPTH];
    t_word                  w_root;

    logic [LEVELS-1:0]      r_vld;
    logic [TOTAL_W-1:0]     r_total  [LEVELS];
    t_status                r_status [LEVELS];

    // take a request only once out of reset
    assign busy     = ~(r_rdy & i_rst_n);
    assign w_accept = start & ~busy;

    assign w_full  = (r_count == L_DEPTH);
    assign w_empty = (r_count == '0);
    assign w_pos   = CMP_W'(i_position);
    assign w_cnt   = CMP_W'(r_count);

    // decode the request: target index, status, and cell command
    always_comb begin
        w_tgt      = '0;
        w_status   = ST_OK;
        w_cmd.ins  = 1'b0;
        w_cmd.del  = 1'b0;
        unique case (i_req_type)
            REQ_INS_AT: begin
                w_tgt = w_pos;
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.ins = w_accept;
                end
            end
            REQ_DEL_AT: begin
                w_tgt = w_pos;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.del = w_accept;
                end
            end
            REQ_INS_LAST: begin
                w_tgt = w_cnt;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.ins = w_accept;
                end
            end
            REQ_DEL_LAST: begin
                w_tgt = w_cnt - CMP_W'(1);
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.del = w_accept;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // row of storage cells; each sees its left and right neighbor
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_word[i - 1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_word[i + 1];
        end
        ilid_cell #(
            .IDX   (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_tgt      (w_tgt),
            .i_cnt      (w_cnt),
            .i_word_in  (i_word_in),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_word     (w_cell_word[i]),
            .o_sel_word (w_sel_word[i])
        );
    end

    // gather the removed word; only the deleted cell drives a nonzero leaf
    ilid_or_tree #(
        .DEPTH (DEPTH)
    ) u_or_tree (
        .i_clk  (i_clk),
        .i_leaf (w_sel_word),
        .o_root (w_root)
    );

    // count and readiness
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy   <= 1'b0;
            r_count <= '0;
        end else begin
            r_rdy   <= 1'b1;
            r_count <= n_count;
        end
    end

    // result valids travel alongside the tree levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld[0] <= w_accept;
            for (int k = 1; k < LEVELS; k++) begin
                r_vld[k] <= r_vld[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total[0]  <= TOTAL_W'(n_count);
        r_status[0] <= w_status;
        for (int k = 1; k < LEVELS; k++) begin
            r_total[k]  <= r_total[k - 1];
            r_status[k] <= r_status[k - 1];
        end
    end

    assign o_done          = r_vld[LEVELS - 1];
    assign o_removed_word  = w_root;
    assign o_element_total = r_total[LEVELS - 1];
    assign o_status        = r_status[LEVELS - 1];

endmodule

`default_nettype wire

// File: src/ilid_checker.sv
`default_nettype none

module ilid_checker #(
    parameter int DEPTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  wire                 o_done,
    input  ilid_pkg::t_word     o_removed_word,
    input  wire  [6:0]          o_element_total,
    input  ilid_pkg::t_status   o_status
);
    import ilid_pkg::*;

    localparam int LEVELS = ilid_levels(DEPTH);

    // every request comes back after the fixed tree latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LEVELS o_done)
        else $error("result missing after request");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // failed requests return no word
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_removed_word == '0))
        else $error("nonzero word on failed request");

    // an empty report means the list holds nothing
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_EMPTY)) |-> (o_element_total == 7'd0))
        else $error("empty status with nonzero total");

endmodule

bind indexed_list_insert_delete_unit ilid_checker #(
    .DEPTH (DEPTH)
) u_ilid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_removed_word  (o_removed_word),
    .o_element_total (o_element_total),
    .o_status        (o_status)
);

`default_nettype wire
